// ===== rtl/core/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the set-associative cache
// Geometry limits, command codes, config register indices, the per-set tag/age row and lookup result.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int MemWords      = 65536;
    localparam int MaxSets       = 64;
    localparam int MaxWays       = 4;
    localparam int MaxBlockWords = 8;

    localparam int AddrW   = $clog2(MemWords);
    localparam int SetW    = $clog2(MaxSets);
    localparam int WayW    = $clog2(MaxWays);
    localparam int OffW    = $clog2(MaxBlockWords);
    localparam int LineW   = SetW + WayW;
    localparam int Lines   = MaxSets * MaxWays;
    localparam int DsAddrW = LineW + OffW;
    localparam int TagW    = 16;
    localparam int AgeW    = 2;

    localparam logic [2:0] CMD_PRELOAD = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_FLUSH   = 3'd3;
    localparam logic [2:0] CMD_PEEK    = 3'd4;

    localparam logic [1:0] CFG_BLOCK_LOG = 2'd0;
    localparam logic [1:0] CFG_SETS_LOG  = 2'd1;
    localparam logic [1:0] CFG_WAYS      = 2'd2;

    typedef struct packed {
        logic [MaxWays-1:0][AgeW-1:0] ages;
        logic [MaxWays-1:0][TagW-1:0] tags;
    } t_row;

    typedef struct packed {
        logic                         hit;
        logic                         wb;
        logic [WayW-1:0]              way;
        logic [MaxWays-1:0][AgeW-1:0] ages;
    } t_look;

endpackage

// ===== rtl/core/sac_lru.sv =====
// ----------------------------------------------------------------------------
// sac_lru: tag compare, victim choice and age update for one set
// Works on the row read from the set memory and the set's valid/dirty bits.
// ----------------------------------------------------------------------------
module sac_lru
    import sac_pkg::*;
(
    input  t_row               i_row,
    input  logic [MaxWays-1:0] i_valid,
    input  logic [MaxWays-1:0] i_dirty,
    input  logic [TagW-1:0]    i_tag,
    input  logic [2:0]         i_ways,
    output t_look              o_look
);

    logic [AgeW-1:0]              ways_m1;
    logic [MaxWays-1:0][AgeW-1:0] eff_age;
    logic                         hit;
    logic                         found;
    logic [WayW-1:0]              hit_way;
    logic [WayW-1:0]              vic_way;
    logic [WayW-1:0]              way;
    logic [AgeW-1:0]              bound;

    assign ways_m1 = AgeW'(i_ways - 3'd1);

    always_comb begin
        hit     = 1'b0;
        found   = 1'b0;
        hit_way = '0;
        vic_way = '0;
        for (int i = 0; i < MaxWays; i++) begin
            eff_age[i] = i_valid[i] ? i_row.ages[i] : ways_m1;
        end
        for (int i = 0; i < MaxWays; i++) begin
            if (i < int'(i_ways)) begin
                if (i_valid[i] && i_row.tags[i] == i_tag) begin
                    hit     = 1'b1;
                    hit_way = WayW'(i);
                end
                if (!found) begin
                    if (!i_valid[i]) begin
                        vic_way = WayW'(i);
                        found   = 1'b1;
                    end else if (eff_age[i] == ways_m1) begin
                        vic_way = WayW'(i);
                    end
                end
            end
        end
        way   = hit ? hit_way : vic_way;
        bound = eff_age[way];
        for (int i = 0; i < MaxWays; i++) begin
            o_look.ages[i] = i_row.ages[i];
            if (i < int'(i_ways) && eff_age[i] < bound) begin
                o_look.ages[i] = eff_age[i] + AgeW'(1);
            end
        end
        o_look.ages[way] = '0;
        o_look.hit       = hit;
        o_look.way       = way;
        o_look.wb        = !hit && !found && i_valid[vic_way] && i_dirty[vic_way];
    end

endmodule

// ===== rtl/core/set_assoc_write_back_cache.sv =====
// ----------------------------------------------------------------------------
// set_assoc_write_back_cache: write-back, write-allocate cache with LRU ages
// Backing memory, data store and per-set tag/age rows in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s         in         i_s_tvalid / o_s_tready   command, word_address, write_data
//  m         out        o_m_tvalid / i_m_tready   read_data, flags, hit and miss totals
//  cfg       in         i_cfg_we                  register index, value
//
// Preload and unknown commands are answered straight from idle. A miss first writes a
// dirty victim back to memory and then fills the block word by word from memory;
// flush reads each set's row and visits its ways one per cycle unless a line needs
// a write-back, writing back every valid dirty line. All of it is paced by the
// single port of each memory. After reset all 65536 words of the backing memory are
// cleared before the first item is accepted. A held result blocks the next item.
module set_assoc_write_back_cache
    import sac_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [55:0]  i_s_tdata,   // command[2:0], word_address[18:3], write_data[50:19]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // read_data[31:0], was_hit[32], did_write_back[33],
                                      // hit_total[65:34], miss_total[97:66]
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [2:0]   i_cfg_data
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_PEEK    = 4'd2;
    localparam logic [3:0] ST_LOOK    = 4'd3;
    localparam logic [3:0] ST_WB      = 4'd4;
    localparam logic [3:0] ST_FILL    = 4'd5;
    localparam logic [3:0] ST_ACC     = 4'd6;
    localparam logic [3:0] ST_RDOUT   = 4'd7;
    localparam logic [3:0] ST_FL_ROW  = 4'd8;
    localparam logic [3:0] ST_FL_LINE = 4'd9;

    logic [31:0] mem [MemWords];
    logic [31:0] ds [MaxSets*MaxWays*MaxBlockWords];
    t_row        rows [MaxSets];

    logic               mem_we, mem_re, ds_we, ds_re, row_re, row_we;
    logic [AddrW-1:0]   mem_waddr, mem_raddr;
    logic [31:0]        mem_wdata, mem_q, ds_wdata, ds_q;
    logic [DsAddrW-1:0] ds_waddr, ds_raddr;
    logic [SetW-1:0]    row_raddr;
    t_row               row_wdata, row_q;

    logic [3:0]        r_state, n_state;
    logic [AddrW-1:0]  r_clr, n_clr;
    logic [1:0]        r_bl, n_bl;
    logic [2:0]        r_sl, n_sl;
    logic [2:0]        r_ways, n_ways;
    logic [Lines-1:0]  r_valid, n_valid, r_dirty, n_dirty;
    logic [2:0]        r_cmd, n_cmd;
    logic [AddrW-1:0]  r_addr, n_addr;
    logic [31:0]       r_wdata, n_wdata;
    logic [WayW-1:0]   r_way, n_way;
    logic [SetW-1:0]   r_lset, n_lset;
    logic [3:0]        r_cnt, n_cnt;
    logic [AddrW-1:0]  r_wb_base, n_wb_base;
    logic              r_wb, n_wb, r_hit, n_hit;
    logic [SetW-1:0]   r_fset, n_fset;
    logic [WayW-1:0]   r_fway, n_fway;
    logic [31:0]       r_hits, n_hits, r_misses, n_misses;
    logic              r_ovalid, n_ovalid;
    logic [31:0]       r_rd, n_rd;
    logic              r_ohit, n_ohit, r_owb, n_owb;

    logic [2:0]        eff_sl, eff_ways;
    logic [3:0]        words;
    logic [OffW-1:0]   off_mask;
    logic [SetW-1:0]   set_mask;
    logic [3:0]        shift_ts;
    logic [2:0]        in_cmd;
    logic [AddrW-1:0]  in_addr;
    logic [31:0]       in_wdata;
    logic [SetW-1:0]   in_set, a_set;
    logic [OffW-1:0]   a_off;
    logic [TagW-1:0]   a_tag;
    logic              accept, out_free;
    logic [LineW-1:0]  fl_line;
    t_look             look;

    assign eff_sl   = (r_sl > 3'd6) ? 3'd6 : r_sl;
    assign eff_ways = (r_ways == 3'd0) ? 3'd1 : ((r_ways > 3'd4) ? 3'd4 : r_ways);
    assign words    = 4'd1 << r_bl;
    assign off_mask = OffW'(words - 4'd1);
    assign set_mask = SetW'((7'd1 << eff_sl) - 7'd1);
    assign shift_ts = {2'b00, r_bl} + {1'b0, eff_sl};

    assign in_cmd   = i_s_tdata[2:0];
    assign in_addr  = i_s_tdata[18:3];
    assign in_wdata = i_s_tdata[50:19];
    assign in_set   = SetW'(in_addr >> r_bl) & set_mask;
    assign a_set    = SetW'(r_addr >> r_bl) & set_mask;
    assign a_off    = OffW'(r_addr) & off_mask;
    assign a_tag    = TagW'(r_addr >> shift_ts);
    assign fl_line  = {r_fset, r_fway};

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_misses, r_hits, r_owb, r_ohit, r_rd};

    sac_lru u_lru (
        .i_row   (row_q),
        .i_valid (r_valid[{a_set, {WayW{1'b0}}} +: MaxWays]),
        .i_dirty (r_dirty[{a_set, {WayW{1'b0}}} +: MaxWays]),
        .i_tag   (a_tag),
        .i_ways  (eff_ways),
        .o_look  (look)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            ds[ds_waddr] <= ds_wdata;
        end
        if (ds_re) begin
            ds_q <= ds[ds_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            rows[a_set] <= row_wdata;
        end
        if (row_re) begin
            row_q <= rows[row_raddr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_bl      = r_bl;
        n_sl      = r_sl;
        n_ways    = r_ways;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_wdata   = r_wdata;
        n_way     = r_way;
        n_lset    = r_lset;
        n_cnt     = r_cnt;
        n_wb_base = r_wb_base;
        n_wb      = r_wb;
        n_hit     = r_hit;
        n_fset    = r_fset;
        n_fway    = r_fway;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_rd      = r_rd;
        n_ohit    = r_ohit;
        n_owb     = r_owb;

        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = in_addr;
        ds_we     = 1'b0;
        ds_waddr  = {a_set, r_way, a_off};
        ds_wdata  = r_wdata;
        ds_re     = 1'b0;
        ds_raddr  = {a_set, r_way, a_off};
        row_re    = 1'b0;
        row_raddr = in_set;
        row_we    = 1'b0;
        row_wdata = row_q;

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + AddrW'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = in_cmd;
                    n_addr  = in_addr;
                    n_wdata = in_wdata;
                    n_wb    = 1'b0;
                    n_hit   = 1'b0;
                    case (in_cmd)
                        CMD_PRELOAD: begin
                            mem_we    = 1'b1;
                            mem_waddr = in_addr;
                            mem_wdata = in_wdata;
                            n_ovalid  = 1'b1;
                            n_rd      = '0;
                            n_ohit    = 1'b0;
                            n_owb     = 1'b0;
                        end
                        CMD_READ, CMD_WRITE: begin
                            row_re  = 1'b1;
                            n_state = ST_LOOK;
                        end
                        CMD_FLUSH: begin
                            n_fset  = '0;
                            n_fway  = '0;
                            n_state = ST_FL_ROW;
                        end
                        CMD_PEEK: begin
                            mem_re  = 1'b1;
                            n_state = ST_PEEK;
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_rd     = '0;
                            n_ohit   = 1'b0;
                            n_owb    = 1'b0;
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                n_ovalid = 1'b1;
                n_rd     = mem_q;
                n_ohit   = 1'b0;
                n_owb    = 1'b0;
                n_state  = ST_IDLE;
            end
            ST_LOOK: begin
                n_way  = look.way;
                n_lset = a_set;
                n_hit  = look.hit;
                row_we = 1'b1;
                row_wdata.ages = look.ages;
                if (!look.hit) begin
                    row_wdata.tags[look.way] = a_tag;
                end
                n_valid[{a_set, look.way}] = 1'b1;
                if (r_cmd == CMD_WRITE) begin
                    n_dirty[{a_set, look.way}] = 1'b1;
                end else if (!look.hit) begin
                    n_dirty[{a_set, look.way}] = 1'b0;
                end
                n_cnt = '0;
                if (look.hit) begin
                    n_hits   = r_hits + 32'd1;
                    ds_waddr = {a_set, look.way, a_off};
                    ds_raddr = {a_set, look.way, a_off};
                    if (r_cmd == CMD_WRITE) begin
                        ds_we    = 1'b1;
                        n_ovalid = 1'b1;
                        n_rd     = '0;
                        n_ohit   = 1'b1;
                        n_owb    = 1'b0;
                        n_state  = ST_IDLE;
                    end else begin
                        ds_re   = 1'b1;
                        n_state = ST_RDOUT;
                    end
                end else begin
                    n_misses = r_misses + 32'd1;
                    if (look.wb) begin
                        n_wb      = 1'b1;
                        n_wb_base = AddrW'(row_q.tags[look.way] << shift_ts)
                                  | AddrW'({a_set, {OffW{1'b0}}} >> (OffW - int'(r_bl)));
                        n_state   = ST_WB;
                    end else begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_WB: begin
                ds_raddr  = {r_lset, r_way, r_cnt[OffW-1:0]};
                ds_re     = r_cnt < words;
                mem_we    = r_cnt != 4'd0;
                mem_waddr = r_wb_base + AddrW'(r_cnt - 4'd1);
                mem_wdata = ds_q;
                n_cnt     = r_cnt + 4'd1;
                if (r_cnt == words) begin
                    n_cnt   = '0;
                    n_state = (r_cmd == CMD_FLUSH) ? ST_FL_LINE : ST_FILL;
                end
            end
            ST_FILL: begin
                mem_re    = r_cnt < words;
                mem_raddr = (r_addr & ~AddrW'(off_mask)) + AddrW'(r_cnt);
                ds_we     = r_cnt != 4'd0;
                ds_waddr  = {r_lset, r_way, OffW'(r_cnt - 4'd1)};
                ds_wdata  = mem_q;
                n_cnt     = r_cnt + 4'd1;
                if (r_cnt == words) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (r_cmd == CMD_WRITE) begin
                    ds_we    = 1'b1;
                    n_ovalid = 1'b1;
                    n_rd     = '0;
                    n_ohit   = r_hit;
                    n_owb    = r_wb;
                    n_state  = ST_IDLE;
                end else begin
                    ds_re   = 1'b1;
                    n_state = ST_RDOUT;
                end
            end
            ST_RDOUT: begin
                n_ovalid = 1'b1;
                n_rd     = ds_q;
                n_ohit   = r_hit;
                n_owb    = r_wb;
                n_state  = ST_IDLE;
            end
            ST_FL_ROW: begin
                row_re    = 1'b1;
                row_raddr = r_fset;
                n_state   = ST_FL_LINE;
            end
            ST_FL_LINE: begin
                if ({1'b0, r_fway} < eff_ways && r_valid[fl_line] && r_dirty[fl_line]) begin
                    n_dirty[fl_line] = 1'b0;
                    n_wb      = 1'b1;
                    n_lset    = r_fset;
                    n_way     = r_fway;
                    n_cnt     = '0;
                    n_wb_base = AddrW'(row_q.tags[r_fway] << shift_ts)
                              | AddrW'({r_fset, {OffW{1'b0}}} >> (OffW - int'(r_bl)));
                    n_state   = ST_WB;
                end else if ({1'b0, r_fway} >= eff_ways - 3'd1) begin
                    if (r_fset == set_mask) begin
                        n_ovalid = 1'b1;
                        n_rd     = '0;
                        n_ohit   = 1'b0;
                        n_owb    = r_wb;
                        n_state  = ST_IDLE;
                    end else begin
                        n_fset  = r_fset + SetW'(1);
                        n_fway  = '0;
                        n_state = ST_FL_ROW;
                    end
                end else begin
                    n_fway = r_fway + WayW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we && (i_cfg_addr inside {CFG_BLOCK_LOG, CFG_SETS_LOG, CFG_WAYS})) begin
            case (i_cfg_addr)
                CFG_BLOCK_LOG: n_bl   = i_cfg_data[1:0];
                CFG_SETS_LOG:  n_sl   = i_cfg_data;
                CFG_WAYS:      n_ways = i_cfg_data;
                default:       n_ways = r_ways;
            endcase
            n_valid = '0;
            n_dirty = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_bl     <= 2'd2;
            r_sl     <= 3'd3;
            r_ways   <= 3'd2;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_bl     <= n_bl;
            r_sl     <= n_sl;
            r_ways   <= n_ways;
            r_valid  <= n_valid;
            r_dirty  <= n_dirty;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_wdata   <= n_wdata;
        r_way     <= n_way;
        r_lset    <= n_lset;
        r_cnt     <= n_cnt;
        r_wb_base <= n_wb_base;
        r_wb      <= n_wb;
        r_hit     <= n_hit;
        r_fset    <= n_fset;
        r_fway    <= n_fway;
        r_rd      <= n_rd;
        r_ohit    <= n_ohit;
        r_owb     <= n_owb;
    end

    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty mark on an invalid line");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !o_s_tready)
        else $error("item accepted during memory clear");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOK |=>
            ((r_hits != $past(r_hits)) != (r_misses != $past(r_misses))))
        else $error("lookup must count exactly one hit or miss");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB || r_state == ST_FILL) |-> r_cnt <= words)
        else $error("block word counter out of range");

endmodule

// ===== sim/set_assoc_write_back_cache_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for set_assoc_write_back_cache
// Drives preload, read, write, flush, peek and unknown-command items through the cache under
// several geometries and idle patterns, predicts every result with a local
// model of memory, tags, ages and data, and compares each result by field.
// ----------------------------------------------------------------------------
module set_assoc_write_back_cache_tb
    import sac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] miss_total;
        logic [31:0] hit_total;
        logic        did_write_back;
        logic        was_hit;
        logic [31:0] read_data;
    } t_reply;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [55:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [2:0]   i_cfg_data = '0;

    set_assoc_write_back_cache u_dut (.*);

    always #6 i_clk = ~i_clk;

    // Local copy of the cache state.
    logic [31:0] mem_words [MemWords];
    logic [31:0] line_data [Lines*MaxBlockWords];
    logic [15:0] line_tag [Lines];
    logic        line_valid [Lines];
    logic        line_dirty [Lines];
    int unsigned line_age [Lines];
    logic [31:0] hits, misses;
    int unsigned cfg_blk, cfg_sets, cfg_ways;

    t_reply      replies_due [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycles = 0;

    function automatic int unsigned blk_log();
        return (cfg_blk > 3) ? 3 : cfg_blk;
    endfunction

    function automatic int unsigned set_log();
        return (cfg_sets > 6) ? 6 : cfg_sets;
    endfunction

    function automatic int unsigned way_count();
        int unsigned w;
        w = cfg_ways;
        if (w == 0) w = 1;
        if (w > MaxWays) w = MaxWays;
        return w;
    endfunction

    function automatic void clear_lines();
        for (int i = 0; i < Lines; i++) begin
            line_tag[i] = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i] = way_count() - 1;
        end
    endfunction

    function automatic void make_youngest(int unsigned set, int unsigned way);
        int unsigned bound;
        bound = line_age[set*MaxWays+way];
        for (int i = 0; i < way_count(); i++)
            if (line_age[set*MaxWays+i] < bound) line_age[set*MaxWays+i]++;
        line_age[set*MaxWays+way] = 0;
    endfunction

    function automatic void spill_line(int unsigned set, int unsigned way);
        int unsigned ln, first;
        ln = set*MaxWays + way;
        first = (line_tag[ln] << (blk_log() + set_log())) | (set << blk_log());
        for (int j = 0; j < (1 << blk_log()); j++)
            mem_words[(first + j) % MemWords] = line_data[ln*MaxBlockWords + j];
    endfunction

    function automatic t_reply cache_reply(logic [2:0] cmd, logic [15:0] addr,
                                           logic [31:0] wdata);
        t_reply r;
        int unsigned bl, sl, nw, off, set, tag, base, way, ln;
        bit hit, found;
        r = '0;
        bl = blk_log();
        sl = set_log();
        nw = way_count();
        case (cmd)
            CMD_PRELOAD: mem_words[addr] = wdata;
            CMD_PEEK: r.read_data = mem_words[addr];
            CMD_FLUSH: begin
                for (int s = 0; s < (1 << sl); s++)
                    for (int w = 0; w < nw; w++)
                        if (line_valid[s*MaxWays+w] && line_dirty[s*MaxWays+w]) begin
                            spill_line(s, w);
                            line_dirty[s*MaxWays+w] = 1'b0;
                            r.did_write_back = 1'b1;
                        end
            end
            CMD_READ, CMD_WRITE: begin
                off = addr & ((1 << bl) - 1);
                set = (addr >> bl) & ((1 << sl) - 1);
                tag = (addr >> (bl + sl)) & 16'hffff;
                base = set * MaxWays;
                way = 0;
                hit = 0;
                found = 0;
                for (int i = 0; i < nw; i++)
                    if (line_valid[base+i] && line_tag[base+i] == tag) begin
                        way = i;
                        hit = 1;
                    end
                if (hit) begin
                    hits++;
                    r.was_hit = 1'b1;
                    make_youngest(set, way);
                end else begin
                    misses++;
                    for (int i = 0; i < nw && !found; i++)
                        if (!line_valid[base+i]) begin
                            way = i;
                            found = 1;
                        end else if (line_age[base+i] == nw - 1) begin
                            way = i;
                        end
                    if (!found && line_dirty[base+way]) begin
                        spill_line(set, way);
                        r.did_write_back = 1'b1;
                    end
                    line_valid[base+way] = 1'b1;
                    line_dirty[base+way] = 1'b0;
                    line_tag[base+way] = 16'(tag);
                    make_youngest(set, way);
                    for (int j = 0; j < (1 << bl); j++)
                        line_data[(base+way)*MaxBlockWords + j] =
                            mem_words[(addr - off + j) % MemWords];
                end
                ln = base + way;
                if (cmd == CMD_WRITE) begin
                    line_data[ln*MaxBlockWords + off] = wdata;
                    line_dirty[ln] = 1'b1;
                end else begin
                    r.read_data = line_data[ln*MaxBlockWords + off];
                end
            end
            default: ;
        endcase
        r.hit_total = hits;
        r.miss_total = misses;
        return r;
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [15:0] addr, logic [31:0] wdata);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {5'd0, wdata, addr, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        replies_due.push_back(cache_reply(cmd, addr, wdata));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [2:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLOCK_LOG: cfg_blk = value & 3;
            CFG_SETS_LOG: cfg_sets = value;
            default: cfg_ways = value;
        endcase
        clear_lines();
    endtask

    task automatic set_geometry(int unsigned b, int unsigned s, int unsigned w);
        write_reg(CFG_BLOCK_LOG, 3'(b));
        write_reg(CFG_SETS_LOG, 3'(s));
        write_reg(CFG_WAYS, 3'(w));
    endtask

    // Addresses mostly from two small windows make hits, conflicts and write-backs common.
    function automatic logic [15:0] pick_addr();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return ($urandom_range(3) == 0 ? 16'hff00 : 16'h0000) | 16'($urandom_range(255));
    endfunction

    task automatic run_random(int n);
        int k;
        logic [2:0] cmd;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 15) cmd = CMD_PRELOAD;
            else if (k < 55) cmd = CMD_READ;
            else if (k < 88) cmd = CMD_WRITE;
            else if (k < 92) cmd = CMD_FLUSH;
            else if (k < 98) cmd = CMD_PEEK;
            else cmd = 3'($urandom_range(7, 5));
            send_item(cmd, pick_addr(), $urandom);
        end
    endtask

    task automatic test_directed();
        send_item(CMD_PRELOAD, 16'h0000, 32'h8000_0000);
        send_item(CMD_PRELOAD, 16'hffff, 32'h7fff_ffff);
        send_item(CMD_PEEK, 16'hffff, '0);
        send_item(CMD_READ, 16'h0000, '0);
        send_item(CMD_READ, 16'h0000, '0);
        send_item(CMD_PRELOAD, 16'h0000, 32'hffff_ffff);
        send_item(CMD_READ, 16'h0000, '0);
        send_item(CMD_WRITE, 16'h0001, 32'h5555_aaaa);
        send_item(CMD_WRITE, 16'h0100, 32'haaaa_5555);
        send_item(CMD_WRITE, 16'h0200, 32'h1234_5678);
        send_item(CMD_READ, 16'h0300, '0);
        send_item(CMD_READ, 16'hffff, '0);
        send_item(CMD_FLUSH, '0, '0);
        send_item(CMD_FLUSH, '0, '0);
        send_item(CMD_PEEK, 16'h0001, '0);
        send_item(3'd5, 16'hffff, 32'hffff_ffff);
        send_item(3'd7, '0, '0);
    endtask

    task automatic test_geometries();
        set_geometry(3, 6, 4);
        run_random(120);
        set_geometry(0, 0, 1);
        run_random(80);
        set_geometry(1, 7, 0);
        run_random(80);
        set_geometry(2, 2, 7);
        run_random(80);
        set_geometry(3, 1, 3);
        run_random(80);
    endtask

    task automatic test_idling();
        send_idle_pct = 74;
        run_random(150);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 74;
        run_random(150);
        drain();
        send_idle_pct = 34;
        recv_stall_pct = 34;
        set_geometry(2, 3, 2);
        run_random(150);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(80);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_reply got, want;
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[97:0];
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = replies_due.pop_front();
                if (got.read_data !== want.read_data) begin
                    $display("%0t: read_data exp %h got %h", $time, want.read_data,
                             got.read_data);
                    errors++;
                end
                if (got.was_hit !== want.was_hit) begin
                    $display("%0t: was_hit exp %b got %b", $time, want.was_hit, got.was_hit);
                    errors++;
                end
                if (got.did_write_back !== want.did_write_back) begin
                    $display("%0t: did_write_back exp %b got %b", $time,
                             want.did_write_back, got.did_write_back);
                    errors++;
                end
                if (got.hit_total !== want.hit_total) begin
                    $display("%0t: hit_total exp %h got %h", $time, want.hit_total,
                             got.hit_total);
                    errors++;
                end
                if (got.miss_total !== want.miss_total) begin
                    $display("%0t: miss_total exp %h got %h", $time, want.miss_total,
                             got.miss_total);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < MemWords; i++) mem_words[i] = '0;
        for (int i = 0; i < Lines*MaxBlockWords; i++) line_data[i] = '0;
        hits = '0;
        misses = '0;
        cfg_blk = 2;
        cfg_sets = 3;
        cfg_ways = 2;
        clear_lines();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        run_random(100);
        test_geometries();
        test_idling();
        drain();
        if (errors == 0 && replies_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
